// ----- src/vthd_pkg.sv -----
// Shared constants and elaboration-time helpers for the heading CORDIC.
// The arctangent table is computed here from a series expansion at elaboration.
// No dependencies.
package vthd_pkg;

  localparam int unsigned IN_W       = 16;
  localparam int unsigned HEAD_W     = 9;
  localparam int unsigned GUARD_BITS = 16;
  // sign, input magnitude after negation, CORDIC growth and guard bits
  localparam int unsigned DATA_W     = IN_W + GUARD_BITS + 3;

  localparam logic [HEAD_W-1:0] HEADING_FULL = 9'd360;
  localparam logic [HEAD_W-1:0] HEADING_HALF = 9'd180;

  // pi with 60 fraction bits, and two pi
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  // Restoring long division, constant use only.
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in radians, 60 fraction bits, i >= 1
  function automatic logic [63:0] atan_rad_q60(input int unsigned i);
    logic [63:0]  acc;
    logic [63:0]  term;
    int unsigned  sh;
    acc = '0;
    for (int unsigned k = 0; k < 32; k++) begin
      sh = i * (2 * k + 1);
      if (sh < 60) begin
        term = div_u64(64'd1 << (60 - sh), 64'(2 * k + 1));
        if (k[0]) acc = acc - term;
        else      acc = acc + term;
      end
    end
    return acc;
  endfunction

  // radians (Q60) to turns with abits fraction bits, rounded half up
  function automatic logic [63:0] rad_to_turns(input logic [63:0] rad,
                                               input int unsigned abits);
    logic [63:0] r;
    logic [63:0] q;
    r = rad;
    q = '0;
    for (int unsigned b = 0; b < abits + 1; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= TWO_PI_Q60) begin
        r    = r - TWO_PI_Q60;
        q[0] = 1'b1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  // table entry i: atan(2^-i) in turns; entry 0 is exactly 1/8 turn
  function automatic logic [63:0] atan_turns(input int unsigned i, input int unsigned abits);
    if (i == 0) return 64'd1 << (abits - 3);
    return rad_to_turns(atan_rad_q60(i), abits);
  endfunction

endpackage

// ----- src/vector_to_heading_degrees.sv -----
// Compass heading from a signed X/Y field reading: atan2(y, x) in degrees plus 180,
// truncated, 0..360. Fully pipelined CORDIC vectoring unit, one stage per
// micro-rotation. Takes one transfer per cycle while in_stall is low. Registered steps:
// input conditioning, ITERATIONS rotation stages, half-turn offset and clamp, scale
// by 360. Empty stages close up while the output is stalled, so input
// keeps flowing until every stage holds an item. Y of zero gives 180, or 360 when
// X is negative. Depends on vthd_pkg.
module vector_to_heading_degrees
  import vthd_pkg::*;
#(
  parameter int unsigned ITERATIONS = 16,
  parameter int unsigned ANGLE_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IN_W-1:0]   in_x_value,
  input  logic signed [IN_W-1:0]   in_y_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [HEAD_W-1:0] out_heading
);

  localparam int unsigned DW = DATA_W;
  localparam int unsigned ZW = ANGLE_BITS + 2;
  localparam int unsigned UW = ANGLE_BITS + 1;
  localparam int unsigned PW = ANGLE_BITS + 10;

  localparam logic signed [ZW-1:0] HALF_TURN = {2'b00, 1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [ZW-1:0] ONE_TURN  = {2'b01, {ANGLE_BITS{1'b0}}};

  // stage 0 is the conditioned input, stage k+1 follows rotation k
  logic        [ITERATIONS:0] v_r;
  logic signed [DW-1:0]       x_r   [ITERATIONS+1];
  logic signed [DW-1:0]       y_r   [ITERATIONS+1];
  logic signed [ZW-1:0]       z_r   [ITERATIONS+1];
  logic        [ITERATIONS:0] byp_r;
  logic        [ITERATIONS:0] neg_r;

  logic signed [DW-1:0]       x_nxt [ITERATIONS+1];
  logic signed [DW-1:0]       y_nxt [ITERATIONS+1];
  logic signed [ZW-1:0]       z_nxt [ITERATIONS+1];
  logic        [ANGLE_BITS-1:0] atan_c [ITERATIONS];

  logic          v_c_r;
  logic [UW-1:0] u_c_r;
  logic [UW-1:0] u_nxt;
  logic signed [ZW-1:0] u_sum;
  logic          byp_c_r;
  logic          neg_c_r;

  logic              out_valid_r;
  logic [HEAD_W-1:0] out_heading_r;
  logic [HEAD_W-1:0] heading_nxt;
  logic [PW-1:0]     prod;

  logic [ITERATIONS:0] en;
  logic                en_c;
  logic                en_out;

  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_rom
    localparam logic [ANGLE_BITS-1:0] ATAN_K = ANGLE_BITS'(atan_turns(k, ANGLE_BITS));
    assign atan_c[k] = ATAN_K;
  end

  // A stage loads when some stage at or after it is empty, or the output drains.
  assign en_out = !out_valid_r || !out_stall;
  assign en_c   = en_out || !v_c_r;
  always_comb begin
    for (int unsigned k = 0; k <= ITERATIONS; k++) begin
      en[k] = en_c || ((~v_r >> k) != '0);
    end
  end
  assign in_stall = !en[0];

  // input conditioning: scale, fold the left half plane over
  always_comb begin
    xs = {{(DW-IN_W-GUARD_BITS){in_x_value[IN_W-1]}}, in_x_value, {GUARD_BITS{1'b0}}};
    ys = {{(DW-IN_W-GUARD_BITS){in_y_value[IN_W-1]}}, in_y_value, {GUARD_BITS{1'b0}}};
    if (in_x_value[IN_W-1]) begin
      x_nxt[0] = -xs;
      y_nxt[0] = -ys;
      z_nxt[0] = in_y_value[IN_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      x_nxt[0] = xs;
      y_nxt[0] = ys;
      z_nxt[0] = '0;
    end
    // micro-rotations
    for (int unsigned k = 0; k < ITERATIONS; k++) begin
      if (!y_r[k][DW-1]) begin
        x_nxt[k+1] = x_r[k] + (y_r[k] >>> k);
        y_nxt[k+1] = y_r[k] - (x_r[k] >>> k);
        z_nxt[k+1] = z_r[k] + signed'({2'b00, atan_c[k]});
      end else begin
        x_nxt[k+1] = x_r[k] - (y_r[k] >>> k);
        y_nxt[k+1] = y_r[k] + (x_r[k] >>> k);
        z_nxt[k+1] = z_r[k] - signed'({2'b00, atan_c[k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int unsigned k = 1; k <= ITERATIONS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]   <= x_nxt[0];
      y_r[0]   <= y_nxt[0];
      z_r[0]   <= z_nxt[0];
      byp_r[0] <= (in_y_value == '0);
      neg_r[0] <= in_x_value[IN_W-1];
    end
    for (int unsigned k = 1; k <= ITERATIONS; k++) begin
      if (en[k]) begin
        x_r[k]   <= x_nxt[k];
        y_r[k]   <= y_nxt[k];
        z_r[k]   <= z_nxt[k];
        byp_r[k] <= byp_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // offset by half a turn, clamp to 0..1 turn
  always_comb begin
    u_sum = z_r[ITERATIONS] + HALF_TURN;
    priority if (u_sum[ZW-1]) u_nxt = '0;
    else if (u_sum > ONE_TURN) u_nxt = UW'(ONE_TURN);
    else                       u_nxt = UW'(u_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (en_c) begin
      v_c_r <= v_r[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      u_c_r   <= u_nxt;
      byp_c_r <= byp_r[ITERATIONS];
      neg_c_r <= neg_r[ITERATIONS];
    end
  end

  // scale by 360 and keep the whole degrees
  always_comb begin
    prod = PW'(u_c_r) * PW'(HEADING_FULL);
    if (byp_c_r) heading_nxt = neg_c_r ? HEADING_FULL : HEADING_HALF;
    else         heading_nxt = prod[ANGLE_BITS +: HEAD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) out_heading_r <= heading_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_heading = out_heading_r;

`ifndef SYNTH
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading <= HEADING_FULL)
    else $error("heading above 360");

  a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with output draining");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r[0] && v_c_r && out_valid_r))
    else $error("input stalled with an empty stage");

  a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[ITERATIONS] && !byp_r[ITERATIONS]) |-> !x_r[ITERATIONS][DW-1])
    else $error("rotated x went negative");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the vector_to_heading_degrees CORDIC heading unit.
// Directed and random X/Y readings are checked against fixed headings or a predictor.
// Depends on vthd_pkg and vector_to_heading_degrees.
`timescale 1ns / 100ps

module testbench
  import vthd_pkg::*;
();

  localparam int unsigned ITERATIONS = 16;
  localparam int unsigned ANGLE_BITS = 24;
  localparam int unsigned TABLE_DEPTH = 24;
  localparam int unsigned LATENCY = ITERATIONS + 3;
  localparam int RANDOM_READINGS = 1250;
  localparam int IDLE_LIMIT = 2000;
  localparam longint unsigned TWO_PI_Q60_TB = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [9:0]      heading;  // -1: take the predictor
  } reading_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [IN_W-1:0]   in_x_value;
  logic signed [IN_W-1:0]   in_y_value;
  logic                     out_valid;
  logic                     out_stall;
  logic        [HEAD_W-1:0] out_heading;

  logic signed [9:0]        row_heading;
  logic                     quiet;
  int                       errors;
  int                       idle_cycles;
  int                       recv_hold;
  logic        [HEAD_W-1:0] want_heading;
  logic        [HEAD_W-1:0] expected_headings[$];
  longint unsigned          arctan_turns[TABLE_DEPTH];
  reading_row_t             directed_rows[18];

  vector_to_heading_degrees #(
    .ITERATIONS(ITERATIONS),
    .ANGLE_BITS(ANGLE_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_x_value(in_x_value),
    .in_y_value(in_y_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_heading(out_heading)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // atan(2^-i) in radians, Q60, by the alternating series
  function automatic longint unsigned series_atan_q60(int unsigned i);
    longint unsigned acc;
    longint unsigned term;
    int unsigned     k;
    int unsigned     sh;
    acc = 0;
    k = 0;
    sh = i;
    while (sh < 60) begin
      term = (64'd1 << (60 - sh)) / longint'(2 * k + 1);
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
      k++;
      sh = i * (2 * k + 1);
    end
    return acc;
  endfunction

  // Q60 radians to turns with ANGLE_BITS fraction bits, rounded half up
  function automatic longint unsigned q60_to_turns(longint unsigned rad);
    longint unsigned rem;
    longint unsigned quo;
    rem = rad % TWO_PI_Q60_TB;
    quo = rad / TWO_PI_Q60_TB;
    for (int b = 0; b < ANGLE_BITS + 1; b++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= TWO_PI_Q60_TB) begin
        rem = rem - TWO_PI_Q60_TB;
        quo = quo | 64'd1;
      end
    end
    return (quo + 1) >> 1;
  endfunction

  function automatic logic [HEAD_W-1:0] heading_of(logic signed [IN_W-1:0] xr,
                                                   logic signed [IN_W-1:0] yr);
    longint half;
    longint full;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint u;
    longint h;
    half = longint'(1) <<< (ANGLE_BITS - 1);
    full = longint'(1) <<< ANGLE_BITS;
    if (yr == 0) return (xr < 0) ? 9'd360 : 9'd180;
    x = longint'(xr) * 65536;
    y = longint'(yr) * 65536;
    z = 0;
    // left half plane: rotate by half a turn first
    if (x < 0) begin
      z = (y > 0) ? half : -half;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ITERATIONS && i < TABLE_DEPTH; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(arctan_turns[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(arctan_turns[i]);
      end
    end
    u = z + half;
    if (u < 0) u = 0;
    if (u > full) u = full;
    h = (u * 360) >>> ANGLE_BITS;
    if (h > 360) h = 360;
    return h[HEAD_W-1:0];
  endfunction

  // check both channels on every rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (row_heading >= 0) expected_headings.push_back(row_heading[HEAD_W-1:0]);
        else expected_headings.push_back(heading_of(in_x_value, in_y_value));
      end
      if (out_valid && !out_stall) begin
        if (expected_headings.size() == 0) begin
          errors++;
          $display("%0t: unexpected heading transfer, expected none, actual %0d",
                   $time, out_heading);
        end else begin
          want_heading = expected_headings.pop_front();
          if (out_heading !== want_heading) begin
            errors++;
            $display("%0t: heading mismatch, expected %0d, actual %0d",
                     $time, want_heading, out_heading);
          end
        end
        recv_hold = quiet ? 0 : $urandom_range(0, 8);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("vector_to_heading_degrees verification failed");
        $finish;
      end
    end
  end

  // receiver: after each transfer, raise out_stall until the random hold count runs out
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_stall <= 1'b1;
      recv_hold <= recv_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // entered and left at a falling edge
  task automatic send_reading(logic signed [IN_W-1:0] xv, logic signed [IN_W-1:0] yv,
                              logic signed [9:0] heading);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_x_value  <= xv;
    in_y_value  <= yv;
    row_heading <= heading;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_headings.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic signed [IN_W-1:0] xv;
    logic signed [IN_W-1:0] yv;
    logic signed [IN_W-1:0] corner;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_x_value  = '0;
    in_y_value  = '0;
    row_heading = -10'sd1;
    out_stall   = 1'b0;
    quiet       = 1'b0;
    errors      = 0;
    idle_cycles = 0;
    recv_hold   = 0;
    arctan_turns[0] = 64'd1 << (ANGLE_BITS - 3);
    for (int i = 1; i < TABLE_DEPTH; i++) arctan_turns[i] = q60_to_turns(series_atan_q60(i));

    // Y zero rows read off directly; the rest go through the predictor
    directed_rows = '{
      '{16'sd0,      16'sd0,      10'sd180},
      '{16'sd1,      16'sd0,      10'sd180},
      '{16'sd32767,  16'sd0,      10'sd180},
      '{-16'sd1,     16'sd0,      10'sd360},
      '{-16'sd32768, 16'sd0,      10'sd360},
      '{16'sd0,      16'sd1,      -10'sd1},
      '{16'sd0,      -16'sd1,     -10'sd1},
      '{16'sd0,      16'sd32767,  -10'sd1},
      '{16'sd0,      -16'sd32768, -10'sd1},
      '{16'sd32767,  16'sd32767,  -10'sd1},
      '{-16'sd32768, -16'sd32768, -10'sd1},
      '{-16'sd32768, 16'sd32767,  -10'sd1},
      '{16'sd32767,  -16'sd32768, -10'sd1},
      '{-16'sd1,     16'sd1,      -10'sd1},
      '{-16'sd1,     -16'sd1,     -10'sd1},
      '{-16'sd32768, 16'sd1,      -10'sd1},
      '{-16'sd32768, -16'sd1,     -10'sd1},
      '{16'sd32767,  16'sd1,      -10'sd1}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_reading(directed_rows[i].x, directed_rows[i].y, directed_rows[i].heading);
    wait_drained();

    for (int n = 0; n < RANDOM_READINGS; n++) begin
      quiet = (n % 250) < 40;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          xv = IN_W'($urandom);
          yv = IN_W'($urandom);
        end
        5: begin
          xv = IN_W'($signed($urandom_range(0, 64)) - 32);
          yv = IN_W'($signed($urandom_range(0, 64)) - 32);
        end
        6: begin
          xv = IN_W'($urandom);
          yv = IN_W'($urandom);
          if ($urandom_range(0, 1)) yv = '0;
          else xv = '0;
        end
        7: begin
          case ($urandom_range(0, 4))
            0: corner = -16'sd32768;
            1: corner = -16'sd1;
            2: corner = 16'sd0;
            3: corner = 16'sd1;
            default: corner = 16'sd32767;
          endcase
          xv = corner;
          yv = IN_W'($urandom);
          if ($urandom_range(0, 1)) begin
            yv = corner;
            xv = IN_W'($urandom);
          end
        end
        8: begin
          // along the diagonals, where the table steps matter most
          xv = IN_W'($urandom);
          yv = $urandom_range(0, 1) ? xv : -xv;
        end
        default: begin
          xv = IN_W'($urandom);
          yv = IN_W'($urandom);
          xv[IN_W-2] = ~xv[IN_W-1];
          yv[IN_W-2] = ~yv[IN_W-1];
        end
      endcase
      send_reading(xv, yv, -10'sd1);
      if (n % 400 == 399) wait_drained();
    end

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && expected_headings.size() == 0) begin
      $display("vector_to_heading_degrees verification clean");
    end else begin
      $display("vector_to_heading_degrees verification failed");
    end
    $finish;
  end

endmodule
